// ----- src/crtt_pkg.sv -----
// Shared types and constants for the CAN retransmission timeout table.
// No dependencies; every other file imports this package.
package crtt_pkg;

   localparam int ID_W            = 29;
   localparam int LEN_W           = 4;
   localparam int DATA_W          = 64;
   localparam int TIME_W          = 16;
   localparam int TRY_W           = 8;
   localparam int CFG_W           = 10;
   localparam int KIND_W          = 2;
   localparam int RKIND_W         = 3;
   localparam int TICK_RESET      = 10;
   localparam int TABLE_DEPTH_DEF = 16;

   typedef enum logic [KIND_W-1:0] {
      KIND_SEND  = 2'd0,
      KIND_REPLY = 2'd1,
      KIND_TICK  = 2'd2,
      KIND_NONE  = 2'd3
   } kind_type;

   typedef enum logic [RKIND_W-1:0] {
      RK_TRANSMIT   = 3'd0,
      RK_RETRANSMIT = 3'd1,
      RK_GIVE_UP    = 3'd2,
      RK_FULL       = 3'd3,
      RK_DELETED    = 3'd4,
      RK_NO_MATCH   = 3'd5
   } rkind_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FLUSH
   } state_type;

   typedef enum logic [1:0] {
      OP_SEND,
      OP_REPLY,
      OP_AGE,
      OP_GIVE_UP
   } op_type;

   typedef struct packed {
      kind_type           kind;
      logic [ID_W-1:0]    frame_id;
      logic               extended;
      logic [LEN_W-1:0]   data_length;
      logic [DATA_W-1:0]  payload;
      logic               track;
      logic [TIME_W-1:0]  timeout_limit;
      logic [TRY_W-1:0]   retry_limit;
   } req_type;

   typedef struct packed {
      logic [ID_W-1:0]    id;
      logic               fmt;
      logic [LEN_W-1:0]   len;
      logic [DATA_W-1:0]  data;
      logic [TIME_W-1:0]  elapsed;
      logic [TRY_W-1:0]   tries;
      logic [TIME_W-1:0]  deadline;
      logic [TRY_W-1:0]   try_cap;
   } entry_type;

   typedef struct packed {
      rkind_type          kind;
      logic [ID_W-1:0]    id;
      logic               fmt;
      logic [LEN_W-1:0]   len;
      logic [DATA_W-1:0]  data;
   } result_type;

   typedef struct packed {
      logic push;
      logic flush;
   } buf_ctl_type;

   typedef struct packed {
      logic pend_valid;
      logic out_free;
      logic can_push;
   } buf_status_type;

   function automatic result_type res_from_entry(rkind_type k, entry_type e);
      result_type r;
      r.kind = k;
      r.id   = e.id;
      r.fmt  = e.fmt;
      r.len  = e.len;
      r.data = e.data;
      return r;
   endfunction

   function automatic result_type res_from_req(rkind_type k, req_type q);
      result_type r;
      r.kind = k;
      r.id   = q.frame_id;
      r.fmt  = q.extended;
      r.len  = q.data_length;
      r.data = q.payload;
      return r;
   endfunction

endpackage

// ----- src/crtt_if.sv -----
// Request and response channel interfaces of the retransmission timeout table.
// Depends on crtt_pkg for field widths.
interface crtt_req_if;
   import crtt_pkg::*;
   logic                 valid;
   logic                 ready;
   logic [KIND_W-1:0]    kind;
   logic [ID_W-1:0]      frame_id;
   logic                 extended;
   logic [LEN_W-1:0]     data_length;
   logic [DATA_W-1:0]    payload;
   logic                 track;
   logic [TIME_W-1:0]    timeout_limit;
   logic [TRY_W-1:0]     retry_limit;

   modport source (output valid, kind, frame_id, extended, data_length, payload, track,
                   timeout_limit, retry_limit, input ready);
   modport sink   (input valid, kind, frame_id, extended, data_length, payload, track,
                   timeout_limit, retry_limit, output ready);
endinterface

interface crtt_rsp_if;
   import crtt_pkg::*;
   logic                 valid;
   logic                 ready;
   logic [RKIND_W-1:0]   result_kind;
   logic [ID_W-1:0]      out_frame_id;
   logic                 out_extended;
   logic [LEN_W-1:0]     out_length;
   logic [DATA_W-1:0]    out_payload;
   logic                 last;

   modport source (output valid, result_kind, out_frame_id, out_extended, out_length,
                   out_payload, last, input ready);
   modport sink   (input valid, result_kind, out_frame_id, out_extended, out_length,
                   out_payload, last, output ready);
endinterface

// ----- src/crtt_slot_mem.sv -----
// Slot store: one write port, one read port with registered read data.
// Depends on crtt_pkg for the entry type.
module crtt_slot_mem #(
   parameter  int DEPTH = crtt_pkg::TABLE_DEPTH_DEF,
   localparam int IW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                clock,
   input  logic                wr_en,
   input  logic [IW-1:0]       wr_addr,
   input  crtt_pkg::entry_type wr_data,
   input  logic                rd_en,
   input  logic [IW-1:0]       rd_addr,
   output crtt_pkg::entry_type rd_data
);
   import crtt_pkg::*;

   entry_type mem [DEPTH];
   entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- src/crtt_result_buf.sv -----
// Result staging: one pending result held back until its last flag is known,
// then the response output register. Depends on crtt_pkg.
module crtt_result_buf (
   input  logic                     clock,
   input  logic                     reset,
   input  crtt_pkg::buf_ctl_type    ctl,
   input  crtt_pkg::result_type     res,
   output crtt_pkg::buf_status_type status,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output crtt_pkg::result_type     rsp_data,
   output logic                     rsp_last
);
   import crtt_pkg::*;

   logic       pend_valid_ff, pend_valid_in;
   result_type pend_ff, pend_in;
   logic       out_valid_ff, out_valid_in;
   result_type out_ff, out_in;
   logic       out_last_ff, out_last_in;
   logic       out_free;
   logic       move;
   logic       take;

   always_comb begin
      out_free = !out_valid_ff || rsp_ready;
      take     = ctl.push && (!pend_valid_ff || out_free);
      move     = pend_valid_ff && out_free && (ctl.push || ctl.flush);

      out_valid_in  = move || (out_valid_ff && !rsp_ready);
      out_in        = move ? pend_ff : out_ff;
      out_last_in   = move ? ctl.flush : out_last_ff;

      pend_valid_in = pend_valid_ff;
      pend_in       = pend_ff;
      if (take) begin
         pend_valid_in = 1'b1;
         pend_in       = res;
      end else if (ctl.flush && move) begin
         pend_valid_in = 1'b0;
      end

      status.pend_valid = pend_valid_ff;
      status.out_free   = out_free;
      status.can_push   = !pend_valid_ff || out_free;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         pend_valid_ff <= pend_valid_in;
         out_valid_ff  <= out_valid_in;
      end
      pend_ff     <= pend_in;
      out_ff      <= out_in;
      out_last_ff <= out_last_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;
   assign rsp_last  = out_last_ff;

endmodule

// ----- src/crtt_seq.sv -----
// Sequencer: walks the slot store one slot per cycle while results can be pushed, for send,
// reply and tick, with the shared saturating add and deadline compare. Depends on crtt_pkg.
module crtt_seq #(
   parameter  int DEPTH = crtt_pkg::TABLE_DEPTH_DEF,
   localparam int IW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_we,
   input  logic [crtt_pkg::CFG_W-1:0]   csr_wdata,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  crtt_pkg::req_type            req_data,
   output crtt_pkg::buf_ctl_type        ctl,
   output crtt_pkg::result_type         res,
   input  crtt_pkg::buf_status_type     buf_st,
   output logic                         mem_rd_en,
   output logic [IW-1:0]                mem_rd_addr,
   input  crtt_pkg::entry_type          mem_rd_data,
   output logic                         mem_wr_en,
   output logic [IW-1:0]                mem_wr_addr,
   output crtt_pkg::entry_type          mem_wr_data
);
   import crtt_pkg::*;

   localparam int CW = $clog2(DEPTH + 1);

   state_type          state_ff, state_in;
   op_type             op_ff, op_in;
   req_type            cmd_ff, cmd_in;
   logic [CW-1:0]      issue_ff, issue_in;
   logic               proc_valid_ff, proc_valid_in;
   logic [IW-1:0]      proc_idx_ff, proc_idx_in;
   logic [DEPTH-1:0]   valid_ff, valid_in;
   logic [DEPTH-1:0]   gu_ff, gu_in;
   logic [CFG_W-1:0]   interval_ff;

   logic               issue_more;
   logic [TIME_W:0]    sum;
   logic [TIME_W-1:0]  aged;
   logic               expired;
   logic               exhausted;
   logic               want;
   logic               stop;
   logic               stall;
   entry_type          new_entry;

   // shared ageing unit
   always_comb begin
      sum       = {1'b0, mem_rd_data.elapsed} + (TIME_W + 1)'(interval_ff);
      aged      = sum[TIME_W] ? {TIME_W{1'b1}} : sum[TIME_W-1:0];
      expired   = aged >= mem_rd_data.deadline;
      exhausted = mem_rd_data.tries >= mem_rd_data.try_cap;
   end

   always_comb begin
      new_entry.id       = cmd_ff.frame_id;
      new_entry.fmt      = cmd_ff.extended;
      new_entry.len      = cmd_ff.data_length;
      new_entry.data     = cmd_ff.payload;
      new_entry.elapsed  = '0;
      new_entry.tries    = TRY_W'(cmd_ff.retry_limit != '0);
      new_entry.deadline = cmd_ff.timeout_limit;
      new_entry.try_cap  = cmd_ff.retry_limit;
   end

   assign issue_more  = issue_ff != CW'(DEPTH);
   assign mem_rd_addr = issue_ff[IW-1:0];
   assign mem_wr_addr = proc_idx_ff;

   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      cmd_in        = cmd_ff;
      issue_in      = issue_ff;
      proc_valid_in = proc_valid_ff;
      proc_idx_in   = proc_idx_ff;
      valid_in      = valid_ff;
      gu_in         = gu_ff;
      ctl           = '0;
      res           = res_from_req(RK_TRANSMIT, cmd_ff);
      mem_rd_en     = 1'b0;
      mem_wr_en     = 1'b0;
      mem_wr_data   = new_entry;
      want          = 1'b0;
      stop          = 1'b0;
      stall         = 1'b0;
      req_ready     = state_ff == ST_IDLE;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd_in        = req_data;
               issue_in      = '0;
               proc_valid_in = 1'b0;
               case (req_data.kind)
                  KIND_SEND: begin
                     if (req_data.track) begin
                        state_in = ST_SCAN;
                        op_in    = OP_SEND;
                     end else begin
                        ctl.push = 1'b1;
                        res      = res_from_req(RK_TRANSMIT, req_data);
                        state_in = ST_FLUSH;
                     end
                  end
                  KIND_REPLY: begin
                     state_in = ST_SCAN;
                     op_in    = OP_REPLY;
                  end
                  KIND_TICK: begin
                     state_in = ST_SCAN;
                     op_in    = OP_AGE;
                  end
                  default: begin
                  end
               endcase
            end
         end

         ST_SCAN: begin
            if (proc_valid_ff) begin
               case (op_ff)
                  OP_SEND: begin
                     if (!valid_ff[proc_idx_ff]) begin
                        want                  = 1'b1;
                        stop                  = 1'b1;
                        res                   = res_from_req(RK_TRANSMIT, cmd_ff);
                        mem_wr_en             = 1'b1;
                        mem_wr_data           = new_entry;
                        valid_in[proc_idx_ff] = 1'b1;
                     end
                  end
                  OP_REPLY: begin
                     if (valid_ff[proc_idx_ff] && mem_rd_data.id == cmd_ff.frame_id &&
                         mem_rd_data.fmt == cmd_ff.extended) begin
                        want                  = 1'b1;
                        stop                  = 1'b1;
                        res                   = res_from_entry(RK_DELETED, mem_rd_data);
                        valid_in[proc_idx_ff] = 1'b0;
                     end
                  end
                  OP_AGE: begin
                     if (valid_ff[proc_idx_ff]) begin
                        mem_wr_en   = 1'b1;
                        mem_wr_data = mem_rd_data;
                        if (expired && exhausted) begin
                           mem_wr_data.elapsed = aged;
                           gu_in[proc_idx_ff]  = 1'b1;
                        end else if (expired) begin
                           mem_wr_data.elapsed = '0;
                           mem_wr_data.tries   = mem_rd_data.tries + TRY_W'(1);
                           want                = 1'b1;
                           res = res_from_entry(RK_RETRANSMIT, mem_rd_data);
                        end else begin
                           mem_wr_data.elapsed = aged;
                        end
                     end
                  end
                  OP_GIVE_UP: begin
                     if (gu_ff[proc_idx_ff]) begin
                        want                  = 1'b1;
                        res                   = res_from_entry(RK_GIVE_UP, mem_rd_data);
                        valid_in[proc_idx_ff] = 1'b0;
                        gu_in[proc_idx_ff]    = 1'b0;
                     end
                  end
                  default: begin
                  end
               endcase
               stall = want && !buf_st.can_push;
               if (stall) begin
                  mem_wr_en = 1'b0;
                  valid_in  = valid_ff;
                  gu_in     = gu_ff;
               end else begin
                  ctl.push = want;
               end
            end

            if (!stall) begin
               if (stop) begin
                  proc_valid_in = 1'b0;
                  state_in      = ST_FLUSH;
               end else if (issue_more) begin
                  mem_rd_en     = 1'b1;
                  issue_in      = issue_ff + CW'(1);
                  proc_valid_in = 1'b1;
                  proc_idx_in   = issue_ff[IW-1:0];
               end else begin
                  proc_valid_in = 1'b0;
                  if (!proc_valid_ff) begin
                     case (op_ff)
                        OP_SEND: begin
                           ctl.push = 1'b1;
                           res      = res_from_req(RK_FULL, cmd_ff);
                           state_in = ST_FLUSH;
                        end
                        OP_REPLY: begin
                           ctl.push = 1'b1;
                           res      = res_from_req(RK_NO_MATCH, cmd_ff);
                           res.len  = '0;
                           res.data = '0;
                           state_in = ST_FLUSH;
                        end
                        OP_AGE: begin
                           op_in    = OP_GIVE_UP;
                           issue_in = '0;
                        end
                        default: begin
                           state_in = ST_FLUSH;
                        end
                     endcase
                  end
               end
            end
         end

         ST_FLUSH: begin
            ctl.flush = 1'b1;
            if (!buf_st.pend_valid || buf_st.out_free) begin
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         op_ff         <= OP_SEND;
         issue_ff      <= '0;
         proc_valid_ff <= 1'b0;
         valid_ff      <= '0;
         gu_ff         <= '0;
         interval_ff   <= CFG_W'(TICK_RESET);
      end else begin
         state_ff      <= state_in;
         op_ff         <= op_in;
         issue_ff      <= issue_in;
         proc_valid_ff <= proc_valid_in;
         valid_ff      <= valid_in;
         gu_ff         <= gu_in;
         if (csr_we) begin
            interval_ff <= csr_wdata;
         end
      end
      cmd_ff      <= cmd_in;
      proc_idx_ff <= proc_idx_in;
   end

endmodule

// ----- src/can_retransmit_timeout_table_core.sv -----
// CAN retransmission timeout table, top level: a table of sent frames awaiting
// a reply, aged by timer ticks. Depends on crtt_pkg, crtt_if, crtt_seq,
// crtt_slot_mem and crtt_result_buf.
//
// One request is worked on at a time; req_bus.ready is high only while the
// block is idle. A sequencer visits the slot store one slot per cycle, when
// no result is held up, through its single read port, so the slot count sets
// the time per request: an untracked send visits no slot, a tracked send or a
// reply up to every slot (a full table or a missed reply), and a tick makes
// two passes over the table. A result is staged until the next one or the end
// of the request is known; each further result needs the output register
// free, so a stalled response channel stretches the time per request.
// Results of one request come out in order with last set on the final one;
// a tick with nothing expired and an unknown kind give no result.
// The register tick_interval, written through csr_we / csr_wdata, resets to 10;
// the user must write it only while idle; the block itself does not enforce it.
module can_retransmit_timeout_table_core #(
   parameter int TABLE_DEPTH = crtt_pkg::TABLE_DEPTH_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   crtt_req_if.sink                   req_bus,
   crtt_rsp_if.source                 rsp_bus,
   input  logic                       csr_we,
   input  logic [crtt_pkg::CFG_W-1:0] csr_wdata
);
   import crtt_pkg::*;

   localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

   req_type        req_data;
   buf_ctl_type    ctl;
   result_type     res;
   buf_status_type buf_st;
   result_type     rsp_data;
   logic           rsp_last;
   logic           mem_rd_en;
   logic [IW-1:0]  mem_rd_addr;
   entry_type      mem_rd_data;
   logic           mem_wr_en;
   logic [IW-1:0]  mem_wr_addr;
   entry_type      mem_wr_data;

   always_comb begin
      req_data.kind          = kind_type'(req_bus.kind);
      req_data.frame_id      = req_bus.frame_id;
      req_data.extended      = req_bus.extended;
      req_data.data_length   = req_bus.data_length;
      req_data.payload       = req_bus.payload;
      req_data.track         = req_bus.track;
      req_data.timeout_limit = req_bus.timeout_limit;
      req_data.retry_limit   = req_bus.retry_limit;
   end

   crtt_seq #(.DEPTH(TABLE_DEPTH)) u_seq (
      .clock       (clock),
      .reset       (reset),
      .csr_we      (csr_we),
      .csr_wdata   (csr_wdata),
      .req_valid   (req_bus.valid),
      .req_ready   (req_bus.ready),
      .req_data    (req_data),
      .ctl         (ctl),
      .res         (res),
      .buf_st      (buf_st),
      .mem_rd_en   (mem_rd_en),
      .mem_rd_addr (mem_rd_addr),
      .mem_rd_data (mem_rd_data),
      .mem_wr_en   (mem_wr_en),
      .mem_wr_addr (mem_wr_addr),
      .mem_wr_data (mem_wr_data)
   );

   crtt_slot_mem #(.DEPTH(TABLE_DEPTH)) u_slot_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   crtt_result_buf u_result_buf (
      .clock     (clock),
      .reset     (reset),
      .ctl       (ctl),
      .res       (res),
      .status    (buf_st),
      .rsp_valid (rsp_bus.valid),
      .rsp_ready (rsp_bus.ready),
      .rsp_data  (rsp_data),
      .rsp_last  (rsp_last)
   );

   assign rsp_bus.result_kind  = rsp_data.kind;
   assign rsp_bus.out_frame_id = rsp_data.id;
   assign rsp_bus.out_extended = rsp_data.fmt;
   assign rsp_bus.out_length   = rsp_data.len;
   assign rsp_bus.out_payload  = rsp_data.data;
   assign rsp_bus.last         = rsp_last;

endmodule

// ----- test/tb_can_retransmit_timeout_table_core.sv -----
`timescale 1ns / 1ps
// Testbench for can_retransmit_timeout_table_core: directed and random requests
// checked against a timeout table model held in the bench.
// Depends on crtt_pkg, crtt_if and the core.
module tb_can_retransmit_timeout_table_core;
   import crtt_pkg::*;

   localparam int DEPTH       = 16;
   localparam int SETTLE      = 80;
   localparam int HOLD_AT     = 45;
   localparam int HOLD_CYCLES = 400;

   typedef struct packed {
      result_type res;
      logic       last;
   } table_result_type;

   logic             clock;
   logic             reset;
   logic             csr_we;
   logic [CFG_W-1:0] csr_wdata;

   crtt_req_if req_bus();
   crtt_rsp_if rsp_bus();

   can_retransmit_timeout_table_core #(.TABLE_DEPTH(DEPTH)) dut (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .rsp_bus   (rsp_bus),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   req_type          frame_requests[$];
   table_result_type awaited_results[$];
   logic [ID_W:0]    tracked_ids[$];     // {extended, frame_id}
   req_type          offered;
   int               queued_total = 0;
   int               sent_count = 0;
   int               error_count = 0;
   int               send_gap = 0;
   int               hold_left = 0;
   bit               quiet = 1'b0;
   bit               long_hold_done = 1'b0;

   logic [CFG_W-1:0] tick_ms;
   logic             slot_used [DEPTH];
   entry_type        slot_entry [DEPTH];

   always #5 clock = ~clock;

   function automatic table_result_type make_result(rkind_type k, logic [ID_W-1:0] id,
                                                    logic fmt, logic [LEN_W-1:0] len,
                                                    logic [DATA_W-1:0] data);
      table_result_type t;
      t.res.kind = k;
      t.res.id   = id;
      t.res.fmt  = fmt;
      t.res.len  = len;
      t.res.data = data;
      t.last     = 1'b0;
      return t;
   endfunction

   function automatic void predict_table_outcome(req_type q);
      table_result_type out_q[$];
      bit               drop [DEPTH];
      int               hit;
      rkind_type        rk;
      logic [TIME_W:0]  sum;
      hit = -1;
      case (q.kind)
         KIND_SEND: begin
            rk = RK_TRANSMIT;
            if (q.track) begin
               for (int s = 0; s < DEPTH; s++)
                  if (!slot_used[s] && hit < 0) hit = s;
               if (hit < 0) begin
                  rk = RK_FULL;
               end else begin
                  slot_used[hit]           = 1'b1;
                  slot_entry[hit].id       = q.frame_id;
                  slot_entry[hit].fmt      = q.extended;
                  slot_entry[hit].len      = q.data_length;
                  slot_entry[hit].data     = q.payload;
                  slot_entry[hit].elapsed  = '0;
                  slot_entry[hit].tries    = (q.retry_limit != 0) ? TRY_W'(1) : TRY_W'(0);
                  slot_entry[hit].deadline = q.timeout_limit;
                  slot_entry[hit].try_cap  = q.retry_limit;
               end
            end
            out_q.push_back(make_result(rk, q.frame_id, q.extended, q.data_length, q.payload));
         end
         KIND_REPLY: begin
            for (int s = 0; s < DEPTH; s++)
               if (hit < 0 && slot_used[s] && slot_entry[s].id == q.frame_id
                   && slot_entry[s].fmt == q.extended)
                  hit = s;
            if (hit >= 0) begin
               out_q.push_back(make_result(RK_DELETED, slot_entry[hit].id, slot_entry[hit].fmt,
                                           slot_entry[hit].len, slot_entry[hit].data));
               slot_used[hit] = 1'b0;
            end else begin
               out_q.push_back(make_result(RK_NO_MATCH, q.frame_id, q.extended, '0, '0));
            end
         end
         KIND_TICK: begin
            for (int s = 0; s < DEPTH; s++) begin
               drop[s] = 1'b0;
               if (!slot_used[s]) continue;
               sum = {1'b0, slot_entry[s].elapsed} + tick_ms;
               slot_entry[s].elapsed = (sum > 17'h0FFFF) ? 16'hFFFF : sum[TIME_W-1:0];
               if (slot_entry[s].elapsed >= slot_entry[s].deadline) begin
                  if (slot_entry[s].tries >= slot_entry[s].try_cap) begin
                     drop[s] = 1'b1;
                  end else begin
                     slot_entry[s].elapsed = '0;
                     slot_entry[s].tries   = slot_entry[s].tries + 1'b1;
                     out_q.push_back(make_result(RK_RETRANSMIT, slot_entry[s].id,
                                                 slot_entry[s].fmt, slot_entry[s].len,
                                                 slot_entry[s].data));
                  end
               end
            end
            for (int s = 0; s < DEPTH; s++)
               if (drop[s]) begin
                  out_q.push_back(make_result(RK_GIVE_UP, slot_entry[s].id, slot_entry[s].fmt,
                                              slot_entry[s].len, slot_entry[s].data));
                  slot_used[s] = 1'b0;
               end
         end
         default: ;
      endcase
      if (out_q.size() > 0) out_q[out_q.size()-1].last = 1'b1;
      foreach (out_q[i]) awaited_results.push_back(out_q[i]);
   endfunction

   function automatic req_type frame_req(kind_type k, logic [ID_W-1:0] id, logic ext,
                                         logic [LEN_W-1:0] len, logic [DATA_W-1:0] data,
                                         logic trk, logic [TIME_W-1:0] tmo,
                                         logic [TRY_W-1:0] cap);
      req_type q;
      q.kind          = k;
      q.frame_id      = id;
      q.extended      = ext;
      q.data_length   = len;
      q.payload       = data;
      q.track         = trk;
      q.timeout_limit = tmo;
      q.retry_limit   = cap;
      return q;
   endfunction

   function automatic req_type random_req();
      req_type       q;
      int            pick;
      logic [ID_W:0] known;
      pick          = $urandom_range(0, 99);
      q.extended    = 1'($urandom_range(0, 1));
      q.frame_id    = (q.extended || $urandom_range(0, 7) == 0) ? ID_W'($urandom)
                                                                 : ID_W'($urandom_range(0, 2047));
      q.data_length = ($urandom_range(0, 9) == 0) ? LEN_W'($urandom_range(9, 15))
                                                  : LEN_W'($urandom_range(0, 8));
      q.payload     = {$urandom, $urandom};
      q.track       = ($urandom_range(0, 7) != 0);
      case ($urandom_range(0, 9))
         0:       q.timeout_limit = TIME_W'($urandom);
         1:       q.timeout_limit = 16'hFFFF;
         default: q.timeout_limit = TIME_W'($urandom_range(0, tick_ms * 5));
      endcase
      case ($urandom_range(0, 9))
         0:       q.retry_limit = 8'hFF;
         1:       q.retry_limit = TRY_W'($urandom);
         default: q.retry_limit = TRY_W'($urandom_range(0, 3));
      endcase
      if (pick < 45) begin
         q.kind = KIND_SEND;
         // duplicate identifiers exercise first-match deletion
         if (tracked_ids.size() > 0 && $urandom_range(0, 6) == 0) begin
            known = tracked_ids[$urandom_range(0, tracked_ids.size() - 1)];
            {q.extended, q.frame_id} = known;
         end
      end else if (pick < 70) begin
         q.kind = KIND_REPLY;
         if (tracked_ids.size() > 0 && $urandom_range(0, 4) != 0) begin
            known = tracked_ids[$urandom_range(0, tracked_ids.size() - 1)];
            {q.extended, q.frame_id} = known;
            if ($urandom_range(0, 9) == 0) q.extended = ~q.extended;
         end
      end else if (pick < 97) begin
         q.kind = KIND_TICK;
      end else begin
         q.kind = KIND_NONE;
      end
      return q;
   endfunction

   task automatic queue_request(req_type q);
      frame_requests.push_back(q);
      queued_total++;
      if (q.kind == KIND_SEND && q.track) begin
         tracked_ids.push_back({q.extended, q.frame_id});
         if (tracked_ids.size() > 32) void'(tracked_ids.pop_front());
      end
   endtask

   task automatic queue_random(int count);
      for (int i = 0; i < count; i++) queue_request(random_req());
   endtask

   task automatic wait_idle();
      while (sent_count != queued_total || awaited_results.size() != 0) @(negedge clock);
      repeat (SETTLE) @(negedge clock);
   endtask

   task automatic set_tick_interval(logic [CFG_W-1:0] v);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= v;
      tick_ms = v;
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic report_field(string name, logic [DATA_W-1:0] want, logic [DATA_W-1:0] got);
      if (want !== got) begin
         error_count++;
         $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
      end
   endtask

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            predict_table_outcome(offered);
            sent_count++;
         end
         if (!(req_bus.valid && !req_bus.ready)) begin
            if (send_gap > 0) begin
               send_gap--;
               req_bus.valid <= 1'b0;
            end else if (frame_requests.size() > 0) begin
               offered = frame_requests.pop_front();
               req_bus.valid         <= 1'b1;
               req_bus.kind          <= offered.kind;
               req_bus.frame_id      <= offered.frame_id;
               req_bus.extended      <= offered.extended;
               req_bus.data_length   <= offered.data_length;
               req_bus.payload       <= offered.payload;
               req_bus.track         <= offered.track;
               req_bus.timeout_limit <= offered.timeout_limit;
               req_bus.retry_limit   <= offered.retry_limit;
               if (!quiet && $urandom_range(0, 3) == 0) send_gap = $urandom_range(1, 9);
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   // response back-pressure, with one long hold-off to fill the block
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_bus.ready <= 1'b0;
      end else if (!long_hold_done && sent_count >= HOLD_AT) begin
         long_hold_done = 1'b1;
         hold_left = HOLD_CYCLES - 1;
         rsp_bus.ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
         hold_left = $urandom_range(0, 8);
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= 1'b1;
      end
   end

   // response monitor
   always @(posedge clock) begin
      table_result_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (awaited_results.size() == 0) begin
            error_count++;
            $display("%0t: unexpected result, expected none, got kind %0d id %0h",
                     $time, rsp_bus.result_kind, rsp_bus.out_frame_id);
         end else begin
            want = awaited_results.pop_front();
            report_field("result_kind", DATA_W'(want.res.kind), DATA_W'(rsp_bus.result_kind));
            report_field("out_frame_id", DATA_W'(want.res.id), DATA_W'(rsp_bus.out_frame_id));
            report_field("out_extended", DATA_W'(want.res.fmt), DATA_W'(rsp_bus.out_extended));
            report_field("out_length", DATA_W'(want.res.len), DATA_W'(rsp_bus.out_length));
            report_field("out_payload", want.res.data, rsp_bus.out_payload);
            report_field("last", DATA_W'(want.last), DATA_W'(rsp_bus.last));
         end
      end
   end

   initial begin
      #5_000_000;
      $display("*** FAILED ***");
      $finish;
   end

   initial begin
      clock                 = 1'b0;
      reset                 = 1'b1;
      csr_we                = 1'b0;
      csr_wdata             = '0;
      req_bus.valid         = 1'b0;
      req_bus.kind          = '0;
      req_bus.frame_id      = '0;
      req_bus.extended      = 1'b0;
      req_bus.data_length   = '0;
      req_bus.payload       = '0;
      req_bus.track         = 1'b0;
      req_bus.timeout_limit = '0;
      req_bus.retry_limit   = '0;
      rsp_bus.ready         = 1'b0;
      tick_ms               = CFG_W'(TICK_RESET);
      foreach (slot_used[s]) slot_used[s] = 1'b0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed: extremes, format matching, retransmit before give-up, full table
      queue_request(frame_req(KIND_SEND, 29'h1FFFFFFF, 1'b1, 4'd8, '1, 1'b0, 16'hFFFF, 8'hFF));
      queue_request(frame_req(KIND_SEND, '0, 1'b0, 4'd0, '0, 1'b1, 16'd0, 8'd0));
      queue_request(frame_req(KIND_SEND, 29'h7FF, 1'b0, 4'd15, {$urandom, $urandom}, 1'b1,
                              16'd10, 8'd2));
      queue_request(frame_req(KIND_SEND, 29'h7FF, 1'b1, 4'd3, {$urandom, $urandom}, 1'b1,
                              16'hFFFF, 8'hFF));
      queue_request(frame_req(KIND_REPLY, 29'h7FF, 1'b1, '0, '0, 1'b0, '0, '0));
      queue_request(frame_req(KIND_REPLY, 29'h123, 1'b0, '0, '0, 1'b0, '0, '0));
      queue_request(frame_req(KIND_TICK, '0, 1'b0, '0, '0, 1'b0, '0, '0));
      queue_request(frame_req(KIND_TICK, '0, 1'b0, '0, '0, 1'b0, '0, '0));
      queue_request(frame_req(KIND_NONE, 29'h55, 1'b1, 4'd2, '1, 1'b1, 16'd1, 8'd1));
      for (int i = 0; i < DEPTH; i++)
         queue_request(frame_req(KIND_SEND, ID_W'($urandom), i[0], LEN_W'(i % 9),
                                 {$urandom, $urandom}, 1'b1, 16'd0, i[0] ? 8'd2 : 8'd0));
      queue_request(frame_req(KIND_SEND, 29'h0ABCDEF, 1'b1, 4'd4, {$urandom, $urandom}, 1'b1,
                              16'd5, 8'd1));
      queue_request(frame_req(KIND_TICK, '0, 1'b0, '0, '0, 1'b0, '0, '0));
      queue_random(50);
      wait_idle();

      // elapsed time saturating at the top of its range
      set_tick_interval(10'd1000);
      queue_request(frame_req(KIND_SEND, 29'h1ABCDEF, 1'b1, 4'd8, {$urandom, $urandom}, 1'b1,
                              16'hFFFF, 8'd2));
      for (int i = 0; i < 70; i++)
         queue_request(frame_req(KIND_TICK, '0, 1'b0, '0, '0, 1'b0, '0, '0));
      queue_random(40);
      wait_idle();

      set_tick_interval(10'd1);
      queue_random(50);
      wait_idle();

      set_tick_interval(10'd535);
      queue_random(40);
      wait_idle();

      set_tick_interval(10'd7);
      quiet = 1'b1;
      queue_random(40);
      wait_idle();

      if (error_count == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule
